/* hdl/hop_count_route_table_assert.svh */
// ----------------------------------------------------------------------------
// hop_count_route_table_assert.svh
// Assertion macros for the route table checker
// ----------------------------------------------------------------------------
`ifndef HOP_COUNT_ROUTE_TABLE_ASSERT_SVH
`define HOP_COUNT_ROUTE_TABLE_ASSERT_SVH

// property that must hold at every edge out of reset
`define HCRT_ASSERT_HOLD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define HCRT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/hcrt_pkg.sv */
// ----------------------------------------------------------------------------
// hcrt_pkg
// Shared constants, codes and beat layouts of the hop count route table
// ----------------------------------------------------------------------------
package hcrt_pkg;

    // table geometry
    localparam int NODE_COUNT = 16;
    localparam int IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    // field widths
    localparam int MODE_W = 2;
    localparam int ADDR_W = 7;
    localparam int HOPS_W = 7;
    localparam int NODE_W = 8;
    localparam int AGE_W  = 8;
    localparam int EXP_W  = 7;

    // configuration register indexes and reset values
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROUTE_LIFETIME = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INFINITE_HOPS  = 1'd1;
    localparam logic [AGE_W-1:0]  LIFETIME_RESET = 8'd90;
    localparam logic [HOPS_W-1:0] INFINITE_RESET = 7'd50;

    // item kinds carried in tuser
    localparam logic [MODE_W-1:0] MODE_REPLY  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

    // input tdata: dest, hops, from_node from the lowest bit up
    localparam int IN_W      = ADDR_W + HOPS_W + NODE_W;
    localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;

    // result beat, status in the lowest bit
    typedef struct packed {
        logic [EXP_W-1:0]  expired_count;
        logic [NODE_W-1:0] next_hop;
        logic              route_found;
        logic              updated;
        logic              status;
    } res_t;

    localparam int RES_W     = $bits(res_t);
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

/* hdl/hop_count_route_table.sv */
// ----------------------------------------------------------------------------
// hop_count_route_table
// Per-destination route table with reply install, lookup and aging tick
// ----------------------------------------------------------------------------
// channel   dir  beat content
// s_*       in   tuser: mode; tdata: dest, hops, from_node
// m_*       out  tdata: status, updated, route_found, next_hop, expired_count
// cfg_*     in   register write: route_lifetime, infinite_hops
//
// reply and lookup: accept, then one access to the entry.
// a tick walks all NODE_COUNT entries, one entry per cycle through the single
// age decrement and compare unit.
// s_tready is high only while the sequencer is idle; a finished result sits
// in the output register, and waits in a holding register while that is full.
// aresetn is synchronous and clears the whole table.
// ----------------------------------------------------------------------------
module hop_count_route_table (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // dest [6:0], hops [13:7], from_node [21:14]
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [hcrt_pkg::S_TDATA_W-1:0]       s_tdata,
    // mode [1:0]
    input  logic [hcrt_pkg::MODE_W-1:0]          s_tuser,
    // status [0], updated [1], route_found [2], next_hop [10:3],
    // expired_count [17:11]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [hcrt_pkg::M_TDATA_W-1:0]       m_tdata,
    // register writes
    input  logic                                 cfg_we,
    input  logic [hcrt_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [hcrt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int N      = hcrt_pkg::NODE_COUNT;
    localparam int IDX_W  = hcrt_pkg::IDX_W;
    localparam int ADDR_W = hcrt_pkg::ADDR_W;
    localparam int HOPS_W = hcrt_pkg::HOPS_W;
    localparam int NODE_W = hcrt_pkg::NODE_W;
    localparam int AGE_W  = hcrt_pkg::AGE_W;
    localparam int EXP_W  = hcrt_pkg::EXP_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N - 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;

    // configuration
    logic [AGE_W-1:0]  lifetime_reg;
    logic [HOPS_W-1:0] inf_hops_reg;

    // route table
    logic              valid_reg [N];
    logic [NODE_W-1:0] next_hop_reg [N];
    logic [HOPS_W-1:0] hop_cnt_reg [N];
    logic [AGE_W-1:0]  age_reg [N];

    // latched item
    logic [hcrt_pkg::MODE_W-1:0] mode_reg;
    logic                        oob_reg;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [HOPS_W-1:0]           hops_reg;
    logic [NODE_W-1:0]           from_reg;
    logic [EXP_W-1:0]            exp_reg, exp_next;

    // output side
    logic                   m_tvalid_reg;
    hcrt_pkg::res_t         m_res_reg;
    hcrt_pkg::res_t         hold_res_reg;
    hcrt_pkg::res_t         res_next;

    // unpacked input beat
    logic [ADDR_W-1:0] in_dest;
    logic [HOPS_W-1:0] in_hops;
    logic [NODE_W-1:0] in_from;
    logic              in_oob;
    logic              accept;
    logic              out_free;
    logic              finish;

    // current entry as seen by the shared unit
    logic              e_valid;
    logic [NODE_W-1:0] e_next_hop;
    logic [HOPS_W-1:0] e_hop_cnt;
    logic [AGE_W-1:0]  e_age;
    logic [AGE_W-1:0]  age_dec;

    // entry write controls
    logic wr_install;
    logic wr_age;
    logic wr_clear;

    assign in_dest = s_tdata[ADDR_W-1:0];
    assign in_hops = s_tdata[ADDR_W +: HOPS_W];
    assign in_from = s_tdata[ADDR_W+HOPS_W +: NODE_W];
    assign in_oob  = (in_dest == '0) || (in_dest > ADDR_W'(N));

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = hcrt_pkg::M_TDATA_W'(m_res_reg);

    assign e_valid    = valid_reg[idx_reg];
    assign e_next_hop = next_hop_reg[idx_reg];
    assign e_hop_cnt  = hop_cnt_reg[idx_reg];
    assign e_age      = age_reg[idx_reg];
    assign age_dec    = e_age - AGE_W'(1);

    // shared unit: one entry per cycle, result and entry writes
    always_comb begin
        res_next   = '0;
        wr_install = 1'b0;
        wr_age     = 1'b0;
        wr_clear   = 1'b0;
        exp_next   = exp_reg;
        idx_next   = idx_reg;
        finish     = 1'b0;
        if (state_reg == ST_EXEC) begin
            finish = 1'b1;
            unique case (mode_reg)
                hcrt_pkg::MODE_REPLY: begin
                    if (oob_reg) begin
                        res_next.status = 1'b1;
                    end else if (hops_reg < e_hop_cnt) begin
                        wr_install       = 1'b1;
                        res_next.updated = 1'b1;
                    end
                end
                hcrt_pkg::MODE_LOOKUP: begin
                    if (oob_reg) begin
                        res_next.status = 1'b1;
                    end else if (e_valid) begin
                        res_next.route_found = 1'b1;
                        res_next.next_hop    = e_next_hop;
                    end
                end
                default: begin
                    res_next = '0;
                end
            endcase
        end else if (state_reg == ST_SCAN) begin
            if (e_valid && (e_age != '0)) begin
                if (age_dec == '0) begin
                    wr_clear = 1'b1;
                    exp_next = exp_reg + EXP_W'(1);
                end else begin
                    wr_age = 1'b1;
                end
            end
            idx_next = idx_reg + IDX_W'(1);
            if (idx_reg == LAST_IDX) begin
                finish                 = 1'b1;
                res_next.expired_count = exp_next;
            end
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser == hcrt_pkg::MODE_TICK) ? ST_SCAN : ST_EXEC;
                end
            end
            ST_EXEC, ST_SCAN: begin
                if (finish) begin
                    state_next = out_free ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers, configuration and output beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            lifetime_reg <= hcrt_pkg::LIFETIME_RESET;
            inf_hops_reg <= hcrt_pkg::INFINITE_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    hcrt_pkg::CFG_ROUTE_LIFETIME: lifetime_reg <= cfg_wdata;
                    hcrt_pkg::CFG_INFINITE_HOPS:  inf_hops_reg <= cfg_wdata[HOPS_W-1:0];
                    default: begin
                        lifetime_reg <= lifetime_reg;
                    end
                endcase
            end
            if (finish && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if ((state_reg == ST_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= s_tuser;
            oob_reg  <= in_oob;
            idx_reg  <= (s_tuser == hcrt_pkg::MODE_TICK) ? '0 : IDX_W'(in_dest - ADDR_W'(1));
            hops_reg <= in_hops;
            from_reg <= in_from;
            exp_reg  <= '0;
        end else if (state_reg == ST_SCAN) begin
            idx_reg <= idx_next;
            exp_reg <= exp_next;
        end
        if (finish && out_free) begin
            m_res_reg <= res_next;
        end else if ((state_reg == ST_DONE) && out_free) begin
            m_res_reg <= hold_res_reg;
        end
        if (finish) begin
            hold_res_reg <= res_next;
        end
    end

    // route table, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                valid_reg[i]    <= 1'b0;
                next_hop_reg[i] <= '0;
                hop_cnt_reg[i]  <= hcrt_pkg::INFINITE_RESET;
                age_reg[i]      <= '0;
            end
        end else begin
            priority if (wr_install) begin
                valid_reg[idx_reg]    <= 1'b1;
                next_hop_reg[idx_reg] <= from_reg;
                hop_cnt_reg[idx_reg]  <= hops_reg;
                age_reg[idx_reg]      <= lifetime_reg;
            end else if (wr_clear) begin
                valid_reg[idx_reg]    <= 1'b0;
                next_hop_reg[idx_reg] <= '0;
                hop_cnt_reg[idx_reg]  <= inf_hops_reg;
                age_reg[idx_reg]      <= '0;
            end else if (wr_age) begin
                age_reg[idx_reg] <= age_dec;
            end
        end
    end

endmodule

/* hdl/hcrt_checker.sv */
// ----------------------------------------------------------------------------
// hcrt_checker
// Port-level checks of the route table, bound to the top level
// ----------------------------------------------------------------------------
`include "hop_count_route_table_assert.svh"

module hcrt_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [hcrt_pkg::M_TDATA_W-1:0]       m_tdata
);

    hcrt_pkg::res_t res;
    logic           stall;
    logic           in_beat;
    logic           oob_beat;
    logic           oob_clean;
    logic           two_kinds;
    logic           exp_ok;

    assign res       = hcrt_pkg::res_t'(m_tdata[hcrt_pkg::RES_W-1:0]);
    assign stall     = m_tvalid && !m_tready;
    assign in_beat   = s_tvalid && s_tready;
    assign oob_beat  = m_tvalid && res.status;
    assign oob_clean = !res.updated && !res.route_found && (res.next_hop == '0)
                       && (res.expired_count == '0);
    assign two_kinds = m_tvalid && res.updated && res.route_found;
    assign exp_ok    = res.expired_count <= hcrt_pkg::EXP_W'(hcrt_pkg::NODE_COUNT);

    // a stalled result beat holds
    `HCRT_ASSERT_NEXT(a_out_hold, aclk, aresetn, stall, m_tvalid && $stable(m_tdata), "stall lost")

    // the sequencer is busy in the cycle after an accept
    `HCRT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, in_beat, !s_tready, "ready after accept")

    // an outside destination reports nothing else
    `HCRT_ASSERT_IMPL(a_oob_clean, aclk, aresetn, oob_beat, oob_clean, "status with other fields")

    // a reply and a lookup flag never appear together
    `HCRT_ASSERT_HOLD(a_one_kind, aclk, aresetn, !two_kinds, "updated and route_found both set")

    // no expiry beyond the table size
    `HCRT_ASSERT_IMPL(a_exp_range, aclk, aresetn, m_tvalid, exp_ok, "expired count above table size")

endmodule

bind hop_count_route_table hcrt_checker u_hcrt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
